// ----- rtl/dlm_pkg.sv -----
// ----------------------------------------------------------------------------
// dlm_pkg
// Shared types and constants of the diagonal Laplacian edge block.
// ----------------------------------------------------------------------------
package dlm_pkg;

  localparam int CFG_W    = 11;
  localparam int CFG_AW   = 3;
  localparam int APB_DW   = 32;
  localparam int PIX_W    = 8;
  localparam int POS_W    = 10;
  localparam int MEAN_W   = 16;
  localparam int FRAC_W   = 8;
  localparam int MIN_SIZE = 3;
  localparam int RES_W    = PIX_W + POS_W + POS_W + MEAN_W + 1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [4:0] DIV_LAST = 5'd16;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef struct packed {
    logic emit;
    logic frame_end;
  } pix_flags_t;

  typedef enum logic {
    XS_RUN,
    XS_DIV
  } x_state_t;

endpackage

// ----- rtl/diagonal_laplacian_with_mean.sv -----
// ----------------------------------------------------------------------------
// diagonal_laplacian_with_mean
// Streaming 3x3 diagonal Laplacian edge measure with a frame mean.
// Throughput: one pixel per cycle, set by one line store read and one write per pixel,
// while the result queue has room and no mean division is running.
// The frame's last pixel waits for the bit-serial mean division.
// Reset (synchronous, active low) clears position, window, sum and queues;
// the line store holds whatever it held and needs no clearing pass.
// ----------------------------------------------------------------------------
module diagonal_laplacian_with_mean import dlm_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              push,
  output logic              full,
  input  logic [PIX_W-1:0]  in_luma,
  output logic              empty,
  input  logic              pop,
  output logic [PIX_W-1:0]  out_edge_value,
  output logic [POS_W-1:0]  out_row,
  output logic [POS_W-1:0]  out_col,
  output logic [MEAN_W-1:0] out_mean_q8,
  output logic              out_frame_done
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int QW = PIX_W + CW + RW + 2 + CW + RW;

  logic [CFG_W-1:0] cfg_width_r, cfg_height_r;
  logic             cfg_wr;
  logic             q_push, q_full, q_pop, q_empty;
  logic [QW-1:0]    q_wdata, q_rdata;
  logic [CW-1:0]    f_col, f_wm1, b_col, b_wm1;
  logic [RW-1:0]    f_row, f_hm1, b_row, b_hm1;
  pix_flags_t       f_flags, b_flags;
  logic [PIX_W-1:0] b_luma;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= WIDTH_RESET;
      cfg_height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  cfg_width_r  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: cfg_height_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = APB_DW'(cfg_width_r);
      REG_FRAME_HEIGHT: prdata = APB_DW'(cfg_height_r);
      default:          prdata = '0;
    endcase
  end

  dlm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_width  (cfg_width_r),
    .cfg_height (cfg_height_r),
    .push       (push),
    .full       (full),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_col      (f_col),
    .q_row      (f_row),
    .q_flags    (f_flags),
    .q_wm1      (f_wm1),
    .q_hm1      (f_hm1)
  );

  assign q_wdata = {in_luma, f_col, f_row, f_flags, f_wm1, f_hm1};

  dlm_fifo #(
    .W     (QW),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .rd_en (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {b_luma, b_col, b_row, b_flags, b_wm1, b_hm1} = q_rdata;

  dlm_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_luma         (b_luma),
    .q_col          (b_col),
    .q_row          (b_row),
    .q_flags        (b_flags),
    .q_wm1          (b_wm1),
    .q_hm1          (b_hm1),
    .empty          (empty),
    .pop            (pop),
    .out_edge_value (out_edge_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_mean_q8    (out_mean_q8),
    .out_frame_done (out_frame_done)
  );

endmodule

// ----- rtl/dlm_ram.sv -----
// ----------------------------------------------------------------------------
// dlm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dlm_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/dlm_fifo.sv -----
// ----------------------------------------------------------------------------
// dlm_fifo
// Small register FIFO; depth must be a power of two, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module dlm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == NW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rp_r];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_comb begin
    wp_nxt  = do_wr ? wp_r + PW'(1) : wp_r;
    rp_nxt  = do_rd ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r + NW'(do_wr) - NW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule

// ----- rtl/dlm_front.sv -----
// ----------------------------------------------------------------------------
// dlm_front
// Raster position tracking and pixel classification.
// ----------------------------------------------------------------------------
module dlm_front import dlm_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [CFG_W-1:0]              cfg_width,
  input  logic [CFG_W-1:0]              cfg_height,
  input  logic                          push,
  output logic                          full,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [$clog2(MAX_WIDTH)-1:0]  q_col,
  output logic [$clog2(MAX_HEIGHT)-1:0] q_row,
  output pix_flags_t                    q_flags,
  output logic [$clog2(MAX_WIDTH)-1:0]  q_wm1,
  output logic [$clog2(MAX_HEIGHT)-1:0] q_hm1
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int WX0 = (WW > CFG_W) ? WW : CFG_W;
  localparam int WX  = (HW > WX0) ? HW : WX0;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [WX-1:0] fw, fh, w_use, h_use;
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;
  logic          accept, row_end, frame_end;

  always_comb begin
    fw = WX'(cfg_width);
    fh = WX'(cfg_height);
    if (fw < WX'(MIN_SIZE)) begin
      w_use = WX'(MIN_SIZE);
    end else if (fw > WX'(MAX_WIDTH)) begin
      w_use = WX'(MAX_WIDTH);
    end else begin
      w_use = fw;
    end
    if (fh < WX'(MIN_SIZE)) begin
      h_use = WX'(MIN_SIZE);
    end else if (fh > WX'(MAX_HEIGHT)) begin
      h_use = WX'(MAX_HEIGHT);
    end else begin
      h_use = fh;
    end
    wm1 = CW'(w_use - WX'(1));
    hm1 = RW'(h_use - WX'(1));
  end

  assign full      = q_full;
  assign accept    = push && !q_full;
  assign row_end   = (col_r >= wm1);
  assign frame_end = row_end && (row_r >= hm1);

  assign q_push            = accept;
  assign q_col             = col_r;
  assign q_row             = row_r;
  assign q_flags.emit      = (row_r >= RW'(2)) && (col_r >= CW'(2));
  assign q_flags.frame_end = frame_end;
  assign q_wm1             = wm1;
  assign q_hm1             = hm1;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ----- rtl/dlm_div.sv -----
// ----------------------------------------------------------------------------
// dlm_div
// Frame mean: (sum << 8) / ((h-1)*(w-1)), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dlm_div import dlm_pkg::*; #(
  parameter int SUM_W = 28,
  parameter int CW    = 10,
  parameter int RW    = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  sum,
  input  logic [CW-1:0]     wm1,
  input  logic [RW-1:0]     hm1,
  output logic              busy,
  output logic              valid,
  output logic [MEAN_W-1:0] mean
);

  localparam int DW = CW + RW;
  localparam int XW = SUM_W + DW;

  logic              busy_r, valid_r, sat_r;
  logic [4:0]        step_r;
  logic [SUM_W-1:0]  sum_r;
  logic [DW-1:0]     den_r, rem_r;
  logic [MEAN_W-1:0] quo_r;
  logic [XW-1:0]     hi;
  logic [DW:0]       trial, diff;
  logic              ge;

  always_comb begin
    hi    = XW'(sum_r) >> FRAC_W;
    trial = {rem_r, quo_r[MEAN_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  assign busy  = busy_r;
  assign valid = valid_r;
  assign mean  = sat_r ? {MEAN_W{1'b1}} : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      step_r  <= '0;
    end else if (start) begin
      busy_r  <= 1'b1;
      valid_r <= 1'b0;
      step_r  <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 5'd1;
      if (step_r == DIV_LAST) begin
        busy_r  <= 1'b0;
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum_r <= sum;
      den_r <= DW'(wm1) * DW'(hm1);
    end else if (busy_r) begin
      if (step_r == '0) begin
        sat_r <= (hi >= XW'(den_r));
        rem_r <= DW'(hi);
        quo_r <= {sum_r[FRAC_W-1:0], {(MEAN_W-FRAC_W){1'b0}}};
      end else begin
        rem_r <= ge ? DW'(diff) : DW'(trial);
        quo_r <= {quo_r[MEAN_W-2:0], ge};
      end
    end
  end

endmodule

// ----- rtl/dlm_back.sv -----
// ----------------------------------------------------------------------------
// dlm_back
// Line store read, window, Laplacian, running sum, mean and result queue.
// ----------------------------------------------------------------------------
module dlm_back import dlm_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  logic [PIX_W-1:0]              q_luma,
  input  logic [$clog2(MAX_WIDTH)-1:0]  q_col,
  input  logic [$clog2(MAX_HEIGHT)-1:0] q_row,
  input  pix_flags_t                    q_flags,
  input  logic [$clog2(MAX_WIDTH)-1:0]  q_wm1,
  input  logic [$clog2(MAX_HEIGHT)-1:0] q_hm1,
  output logic                          empty,
  input  logic                          pop,
  output logic [PIX_W-1:0]              out_edge_value,
  output logic [POS_W-1:0]              out_row,
  output logic [POS_W-1:0]              out_col,
  output logic [MEAN_W-1:0]             out_mean_q8,
  output logic                          out_frame_done
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int SUM_W = $clog2(64'd255 * (MAX_WIDTH - 2) * (MAX_HEIGHT - 2) + 1);

  logic                 x_vld_r;
  logic [PIX_W-1:0]     x_luma_r;
  logic [CW-1:0]        x_col_r;
  logic [RW-1:0]        x_row_r;
  pix_flags_t           x_flags_r;
  logic [CW-1:0]        x_wm1_r;
  logic [RW-1:0]        x_hm1_r;
  logic [2*PIX_W-1:0]   rd;
  logic [PIX_W-1:0]     top, mid;
  logic [PIX_W-1:0]     top0_r, top1_r, mid0_r, bot0_r, bot1_r;
  logic [SUM_W-1:0]     sum_r, sum_add;
  logic [PIX_W+1:0]     diag;
  logic signed [11:0]   lap;
  logic [11:0]          mag_full;
  logic [PIX_W-1:0]     mag;
  x_state_t             state_r, state_nxt;
  logic                 x_fire, div_start, res_push, res_full;
  logic                 div_busy, div_valid;
  logic [MEAN_W-1:0]    div_mean;
  logic [RES_W-1:0]     res_wdata, res_rdata;

  assign q_pop = !q_empty && (!x_vld_r || x_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r <= 1'b0;
    end else if (q_pop) begin
      x_vld_r <= 1'b1;
    end else if (x_fire) begin
      x_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_luma_r  <= q_luma;
      x_col_r   <= q_col;
      x_row_r   <= q_row;
      x_flags_r <= q_flags;
      x_wm1_r   <= q_wm1;
      x_hm1_r   <= q_hm1;
    end
  end

  dlm_ram #(
    .W     (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (x_fire),
    .waddr (x_col_r),
    .wdata ({x_luma_r, mid}),
    .re    (q_pop),
    .raddr (q_col),
    .rdata (rd)
  );

  assign top = rd[PIX_W-1:0];
  assign mid = rd[2*PIX_W-1:PIX_W];

  always_comb begin
    diag     = (PIX_W+2)'(top1_r) + (PIX_W+2)'(top) + (PIX_W+2)'(bot1_r)
             + (PIX_W+2)'(x_luma_r);
    lap      = $signed({1'b0, diag, 1'b0}) - $signed({1'b0, mid0_r, 3'b000});
    mag_full = (lap < 0) ? 12'(-lap) : 12'(lap);
    mag      = (mag_full > 12'(PIX_MAX)) ? PIX_MAX : mag_full[PIX_W-1:0];
    sum_add  = sum_r + SUM_W'(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top0_r <= '0;
      top1_r <= '0;
      mid0_r <= '0;
      bot0_r <= '0;
      bot1_r <= '0;
      sum_r  <= '0;
    end else if (x_fire) begin
      top1_r <= top0_r;
      top0_r <= top;
      mid0_r <= mid;
      bot1_r <= bot0_r;
      bot0_r <= x_luma_r;
      if (x_flags_r.frame_end) begin
        sum_r <= '0;
      end else if (x_flags_r.emit) begin
        sum_r <= sum_add;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      XS_RUN: begin
        if (x_vld_r && x_flags_r.frame_end) begin
          state_nxt = XS_DIV;
        end
      end
      XS_DIV: begin
        if (div_valid && !res_full) begin
          state_nxt = XS_RUN;
        end
      end
      default: state_nxt = XS_RUN;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    x_fire    = 1'b0;
    case (state_r)
      XS_RUN: begin
        div_start = x_vld_r && x_flags_r.frame_end;
        x_fire    = x_vld_r && !x_flags_r.frame_end && (!x_flags_r.emit || !res_full);
      end
      XS_DIV: begin
        x_fire = div_valid && !res_full;
      end
      default: begin
        div_start = 1'b0;
        x_fire    = 1'b0;
      end
    endcase
    res_push = x_fire && x_flags_r.emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= XS_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  dlm_div #(
    .SUM_W (SUM_W),
    .CW    (CW),
    .RW    (RW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .sum   (sum_add),
    .wm1   (x_wm1_r),
    .hm1   (x_hm1_r),
    .busy  (div_busy),
    .valid (div_valid),
    .mean  (div_mean)
  );

  assign res_wdata = {mag,
                      POS_W'(x_row_r - RW'(1)),
                      POS_W'(x_col_r - CW'(1)),
                      x_flags_r.frame_end ? div_mean : {MEAN_W{1'b0}},
                      x_flags_r.frame_end};

  dlm_fifo #(
    .W     (RES_W),
    .DEPTH (2)
  ) u_res (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .rd_en (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign {out_edge_value, out_row, out_col, out_mean_q8, out_frame_done} = res_rdata;

`ifndef ASSERT_OFF
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    x_vld_r && x_flags_r.frame_end |-> x_flags_r.emit)
    else $error("frame end without an interior pixel");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("mean division started while busy");

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == XS_DIV |-> x_vld_r && x_flags_r.frame_end)
    else $error("division wait without a frame end pixel");
`endif

endmodule
